// ----- rtl/vmmr_pkg.sv -----
// ----------------------------------------------------------------------------
// vmmr_pkg
// Shared widths, codes and controller/datapath interface types for the
// vector min/max/mean reducer.
// ----------------------------------------------------------------------------
package vmmr_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int LANES             = 3;
    localparam int TDATA_W           = SAMPLE_W * LANES;
    localparam int ACC_W             = 48;
    localparam int DIV_STEP_W        = $clog2(ACC_W);
    localparam int DEFAULT_MAX_ITEMS = 65536;

    // configuration register indexes
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REDUCE_OP = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_IS_VECTOR = 2'd1;

    // reduce operation codes, anything above OP_MAG gives zero
    localparam logic [2:0] OP_MEAN = 3'd0;
    localparam logic [2:0] OP_MAX  = 3'd1;
    localparam logic [2:0] OP_MIN  = 3'd2;
    localparam logic [2:0] OP_MAG  = 3'd3;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] OUT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] OUT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic take_item;
        logic div_start;
        logic load_result;
    } vmmr_cmd_t;

    typedef struct packed {
        logic op_is_mean;
        logic div_done;
    } vmmr_sts_t;

endpackage

// ----- rtl/vmmr_div.sv -----
// ----------------------------------------------------------------------------
// vmmr_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vmmr_div #(
    parameter int DIVISOR_W = 17
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [vmmr_pkg::ACC_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]       divisor,
    output logic [vmmr_pkg::ACC_W-1:0] quotient,
    output logic                       done
);

    localparam logic [vmmr_pkg::DIV_STEP_W-1:0] LAST_STEP =
        vmmr_pkg::DIV_STEP_W'(vmmr_pkg::ACC_W - 1);

    logic                                busy_reg, busy_next;
    logic [vmmr_pkg::DIV_STEP_W-1:0]     step_reg, step_next;
    logic [DIVISOR_W-1:0]                rem_reg, rem_next;
    logic [vmmr_pkg::ACC_W-1:0]          quo_reg, quo_next;
    logic [DIVISOR_W:0]                  rem_shift;
    logic [DIVISOR_W:0]                  rem_diff;

    assign rem_shift = {rem_reg, quo_reg[vmmr_pkg::ACC_W-1]};
    assign rem_diff  = rem_shift - {1'b0, divisor};

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = dividend;
        end else if (busy_reg) begin
            // quotient bits enter at the bottom as dividend bits leave the top
            if (rem_shift >= {1'b0, divisor}) begin
                rem_next = rem_diff[DIVISOR_W-1:0];
                quo_next = {quo_reg[vmmr_pkg::ACC_W-2:0], 1'b1};
            end else begin
                rem_next = rem_shift[DIVISOR_W-1:0];
                quo_next = {quo_reg[vmmr_pkg::ACC_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = busy_reg && (step_reg == LAST_STEP);

endmodule

// ----- rtl/vmmr_datapath.sv -----
// ----------------------------------------------------------------------------
// vmmr_datapath
// Configuration registers, per-lane accumulators, item counter, mean
// dividers and the output payload register.
// ----------------------------------------------------------------------------
module vmmr_datapath #(
    parameter int MAX_ITEMS = vmmr_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vmmr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vmmr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [vmmr_pkg::TDATA_W-1:0]    s_tdata,
    input  vmmr_pkg::vmmr_cmd_t             cmd,
    output vmmr_pkg::vmmr_sts_t             sts,
    output logic [vmmr_pkg::TDATA_W-1:0]    m_tdata,
    output logic                            m_tuser
);

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int SW    = vmmr_pkg::SAMPLE_W;
    localparam int AW    = vmmr_pkg::ACC_W;

    logic [2:0]       reduce_op_reg;
    logic             is_vector_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             ovf_reg, ovf_next;
    logic             count_full;
    logic             first_item;

    logic [AW-1:0] acc_reg   [vmmr_pkg::LANES];
    logic [AW-1:0] acc_next  [vmmr_pkg::LANES];
    logic [AW-1:0] quot      [vmmr_pkg::LANES];
    logic [SW-1:0] res_lane  [vmmr_pkg::LANES];
    logic [vmmr_pkg::LANES-1:0] div_done;

    logic [vmmr_pkg::TDATA_W-1:0] m_tdata_reg;
    logic                         m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reduce_op_reg <= vmmr_pkg::OP_MEAN;
            is_vector_reg <= 1'b1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                vmmr_pkg::CFG_REDUCE_OP: reduce_op_reg <= cfg_wdata;
                vmmr_pkg::CFG_IS_VECTOR: is_vector_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign count_full = (cnt_reg == CNT_W'(MAX_ITEMS));
    assign first_item = (cnt_reg == '0);

    always_comb begin
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        if (cmd.load_result) begin
            cnt_next = '0;
            ovf_next = 1'b0;
        end else if (cmd.take_item) begin
            if (count_full) begin
                ovf_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
        end
    end

    for (genvar g = 0; g < vmmr_pkg::LANES; g++) begin : g_lane
        logic [SW-1:0] sample;
        logic [AW-1:0] sample_ext;
        logic [SW-1:0] mag;
        logic [AW-1:0] mag_ext;
        logic [AW:0]   sum;
        logic [AW-1:0] sum_sat;
        logic [AW-1:0] abs_acc;
        logic          acc_neg;
        logic          acc_fits;

        assign sample     = s_tdata[g*SW +: SW];
        assign sample_ext = {{(AW-SW){sample[SW-1]}}, sample};
        // magnitude of the most negative sample saturates
        assign mag = (sample == vmmr_pkg::OUT_MIN) ? vmmr_pkg::OUT_MAX :
                     (sample[SW-1] ? (~sample + 1'b1) : sample);
        assign mag_ext = {{(AW-SW){1'b0}}, mag};
        assign sum     = {acc_reg[g][AW-1], acc_reg[g]} + {sample_ext[AW-1], sample_ext};
        assign sum_sat = (sum[AW] != sum[AW-1]) ?
                         (sum[AW] ? vmmr_pkg::ACC_MIN : vmmr_pkg::ACC_MAX) : sum[AW-1:0];

        always_comb begin
            acc_next[g] = acc_reg[g];
            if (cmd.take_item && !count_full) begin
                case (reduce_op_reg)
                    vmmr_pkg::OP_MEAN: acc_next[g] = first_item ? sample_ext : sum_sat;
                    vmmr_pkg::OP_MAX: begin
                        if (first_item || $signed(sample_ext) > $signed(acc_reg[g])) begin
                            acc_next[g] = sample_ext;
                        end
                    end
                    vmmr_pkg::OP_MIN: begin
                        if (first_item || $signed(sample_ext) < $signed(acc_reg[g])) begin
                            acc_next[g] = sample_ext;
                        end
                    end
                    vmmr_pkg::OP_MAG: begin
                        if (first_item || $signed(mag_ext) > $signed(acc_reg[g])) begin
                            acc_next[g] = mag_ext;
                        end
                    end
                    default: acc_next[g] = '0;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            acc_reg[g] <= acc_next[g];
        end

        assign acc_neg  = acc_reg[g][AW-1];
        assign abs_acc  = acc_neg ? (~acc_reg[g] + 1'b1) : acc_reg[g];
        assign acc_fits = (acc_reg[g][AW-1:SW-1] == '0) || (acc_reg[g][AW-1:SW-1] == '1);

        vmmr_div #(
            .DIVISOR_W (CNT_W)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (cmd.div_start),
            .dividend (abs_acc),
            .divisor  (cnt_reg),
            .quotient (quot[g]),
            .done     (div_done[g])
        );

        always_comb begin
            res_lane[g] = '0;
            if (g == 0 || is_vector_reg) begin
                case (reduce_op_reg)
                    vmmr_pkg::OP_MEAN: begin
                        if (cnt_reg == '0) begin
                            res_lane[g] = '0;
                        end else if (!acc_neg) begin
                            res_lane[g] = (quot[g][AW-1:SW-1] != '0) ? vmmr_pkg::OUT_MAX
                                                                     : quot[g][SW-1:0];
                        end else if (quot[g] > {{(AW-SW){1'b0}}, vmmr_pkg::OUT_MIN}) begin
                            res_lane[g] = vmmr_pkg::OUT_MIN;
                        end else begin
                            res_lane[g] = ~quot[g][SW-1:0] + 1'b1;
                        end
                    end
                    vmmr_pkg::OP_MAX, vmmr_pkg::OP_MIN, vmmr_pkg::OP_MAG: begin
                        if (acc_fits) begin
                            res_lane[g] = acc_reg[g][SW-1:0];
                        end else begin
                            res_lane[g] = acc_neg ? vmmr_pkg::OUT_MIN : vmmr_pkg::OUT_MAX;
                        end
                    end
                    default: res_lane[g] = '0;
                endcase
            end
        end

        always_ff @(posedge aclk) begin
            if (cmd.load_result) begin
                m_tdata_reg[g*SW +: SW] <= res_lane[g];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_result) begin
            m_tuser_reg <= ovf_reg;
        end
    end

    // all lanes start together, so lane zero speaks for the set
    assign sts.div_done   = div_done[0];
    assign sts.op_is_mean = (reduce_op_reg == vmmr_pkg::OP_MEAN);

    assign m_tdata = m_tdata_reg;
    assign m_tuser = m_tuser_reg;

endmodule

// ----- rtl/vmmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// vmmr_ctrl
// Sequencer: accumulate, start the mean division, load the output
// register, and own the input and output handshakes.
// ----------------------------------------------------------------------------
module vmmr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    input  logic                s_tlast,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  vmmr_pkg::vmmr_sts_t sts,
    output vmmr_pkg::vmmr_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_ACCEPT = 4'b0001,
        ST_START  = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_LOAD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_ACCEPT);
    assign out_free = !m_valid_reg || m_tready;

    always_comb begin
        state_next      = state_reg;
        cmd.take_item   = 1'b0;
        cmd.div_start   = 1'b0;
        cmd.load_result = 1'b0;
        case (state_reg)
            ST_ACCEPT: begin
                cmd.take_item = s_tvalid;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (sts.op_is_mean) begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end else begin
                    state_next = ST_LOAD;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    cmd.load_result = 1'b1;
                    state_next      = ST_ACCEPT;
                end
            end
            default: state_next = ST_ACCEPT;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_result) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCEPT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_result |-> (!m_valid_reg || m_tready))
        else $error("result loaded over a pending transaction");

    // division only runs for the mean
    a_div_mean: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> sts.op_is_mean)
        else $error("divider started outside mean mode");

    // the divider finishes only while the sequencer waits on it
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        sts.div_done |-> (state_reg == ST_DIV))
        else $error("divider done outside the divide state");

    // a last item always leads to a loaded result before more input
    a_last_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.take_item && s_tlast) |=> !s_tready)
        else $error("input still open after the last transaction");

endmodule

// ----- rtl/vector_min_max_mean_reducer_top.sv -----
// ----------------------------------------------------------------------------
// vector_min_max_mean_reducer_top
// Streaming per-component mean / max / min / largest-magnitude reducer
// over three-component Q16.16 samples.
//
//   channel  dir  payload                                    end marker
//   s_       in   tdata: sample_x, sample_y, sample_z        tlast: is_last
//   m_       out  tdata: result_x, result_y, result_z        tuser: count_overflow
//   cfg_     in   index 0 reduce_op, index 1 is_vector       none
//
// Samples are taken one per cycle while an array accumulates.
// After the last sample the input stalls until the result enters the output
// register: via the start and load states for max/min/magnitude, and for mean
// also the divide state: a 48-step restoring divider, one bit per cycle, three lanes.
// A result waiting on m_tready holds the next array only at its end.
// Reset (aresetn, synchronous, active low) clears the count and restores
// reduce_op to mean and is_vector to one.
// ----------------------------------------------------------------------------
module vector_min_max_mean_reducer_top #(
    parameter int MAX_ITEMS = vmmr_pkg::DEFAULT_MAX_ITEMS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [vmmr_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [vmmr_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [vmmr_pkg::TDATA_W-1:0]    s_tdata,   // sample_x, sample_y, sample_z
    input  logic                            s_tlast,   // is_last
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [vmmr_pkg::TDATA_W-1:0]    m_tdata,   // result_x, result_y, result_z
    output logic                            m_tuser    // count_overflow
);

    vmmr_pkg::vmmr_cmd_t cmd;
    vmmr_pkg::vmmr_sts_t sts;

    vmmr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vmmr_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

// ----- verif/vector_min_max_mean_reducer_top_tb.sv -----
// ----------------------------------------------------------------------------
// vector_min_max_mean_reducer_top_tb
// Self-checking bench for the streaming min/max/mean/magnitude reducer.
// A queue-fed driver sends sample transactions with random gaps. Every
// accepted transaction updates a bench-side copy of the per-lane reductions,
// and a closing transaction queues the expected result. A monitor checks each
// result transaction lane by lane, plus the overflow flag. Directed arrays
// cover the extremes, every mode, scalar mode, ignored register indexes and a
// mode switch inside an array.
// Random batches follow, with a long back-pressure hold on the result side.
// ----------------------------------------------------------------------------
module vector_min_max_mean_reducer_top_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          ARRAY_LIMIT   = vmmr_pkg::DEFAULT_MAX_ITEMS;
    localparam int          RANDOM_ITEMS  = 1600;
    localparam int          SETTLE_CYCLES = 64;
    localparam int          HOLD_CYCLES   = 500;
    localparam int          CYCLE_LIMIT   = 2_000_000;

    localparam logic [2:0]  OP_ZERO_FIRST = 3'd4;
    localparam logic [2:0]  OP_ZERO_LAST  = 3'd7;
    localparam logic [vmmr_pkg::CFG_ADDR_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [vmmr_pkg::CFG_ADDR_W-1:0] CFG_SPARE_3 = 2'd3;

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint OUT_HI = 64'sh0000_0000_7FFF_FFFF;
    localparam longint OUT_LO = -OUT_HI - 1;

    typedef struct packed {
        logic [vmmr_pkg::TDATA_W-1:0] data;
        logic                         last;
    } sample_t;

    typedef struct packed {
        logic [vmmr_pkg::LANES-1:0][vmmr_pkg::SAMPLE_W-1:0] lanes;
        logic                                               overflow;
    } reduction_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [vmmr_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [vmmr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [vmmr_pkg::TDATA_W-1:0]    s_tdata   = '0;
    logic                            s_tlast   = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [vmmr_pkg::TDATA_W-1:0]    m_tdata;
    logic                            m_tuser;

    sample_t    pending_samples[$];
    reduction_t expected_reductions[$];

    // bench copy of the block state and registers
    longint      lane_acc[vmmr_pkg::LANES];
    int unsigned item_count    = 0;
    bit          overflow_seen = 1'b0;
    logic [2:0]  op_shadow     = vmmr_pkg::OP_MEAN;
    bit          vec_shadow    = 1'b1;

    bit          idle_en    = 1'b1;
    bit          hold_armed = 1'b0;
    bit          hold_done  = 1'b0;
    int          hold_left  = 0;
    int          s_gap      = 0;
    int          m_gap      = 0;
    logic        s_taken    = 1'b0;
    int          mismatches = 0;
    int unsigned cycle_count = 0;

    vector_min_max_mean_reducer_top #(
        .MAX_ITEMS (ARRAY_LIMIT)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic longint saturate(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // fold one accepted sample into the lane reductions, close the array on last
    function automatic void fold_sample(input logic [vmmr_pkg::TDATA_W-1:0] data,
                                        input logic last);
        longint     comp;
        longint     a;
        longint     r;
        bit         first;
        int         c;
        reduction_t res;
        first = (item_count == 0);
        if (item_count < ARRAY_LIMIT) begin
            for (c = 0; c < vmmr_pkg::LANES; c++) begin
                comp = longint'($signed(data[c*vmmr_pkg::SAMPLE_W +: vmmr_pkg::SAMPLE_W]));
                a = lane_acc[c];
                case (op_shadow)
                    vmmr_pkg::OP_MEAN: a = first ? comp : saturate(a + comp, ACC_LO, ACC_HI);
                    vmmr_pkg::OP_MAX:  a = (first || comp > a) ? comp : a;
                    vmmr_pkg::OP_MIN:  a = (first || comp < a) ? comp : a;
                    vmmr_pkg::OP_MAG: begin
                        // most negative input saturates to the top of the range
                        comp = saturate((comp < 0) ? -comp : comp, OUT_LO, OUT_HI);
                        a = (first || comp > a) ? comp : a;
                    end
                    default: a = 0;
                endcase
                lane_acc[c] = a;
            end
            item_count++;
        end else begin
            overflow_seen = 1'b1;
        end
        if (!last) return;
        for (c = 0; c < vmmr_pkg::LANES; c++) begin
            if (c > 0 && !vec_shadow) begin
                r = 0;
            end else if (op_shadow == vmmr_pkg::OP_MEAN) begin
                r = (item_count != 0) ? lane_acc[c] / longint'(item_count) : 0;
                r = saturate(r, OUT_LO, OUT_HI);
            end else if (op_shadow <= vmmr_pkg::OP_MAG) begin
                r = saturate(lane_acc[c], OUT_LO, OUT_HI);
            end else begin
                r = 0;
            end
            res.lanes[c] = r[vmmr_pkg::SAMPLE_W-1:0];
        end
        res.overflow = overflow_seen;
        expected_reductions.push_back(res);
        for (c = 0; c < vmmr_pkg::LANES; c++) lane_acc[c] = 0;
        item_count = 0;
        overflow_seen = 1'b0;
    endfunction

    function automatic void report_mismatch(input string field,
                                            input logic [vmmr_pkg::SAMPLE_W-1:0] want,
                                            input logic [vmmr_pkg::SAMPLE_W-1:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field, want, got);
    endfunction

    // monitor: predict on input transactions, check result transactions
    always @(posedge aclk) begin
        reduction_t want;
        int         c;
        s_taken <= s_tvalid && s_tready;
        if (aresetn) begin
            if (s_tvalid && s_tready)
                fold_sample(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_reductions.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result transaction with none expected: %h",
                                 $realtime, m_tdata);
                end else begin
                    want = expected_reductions.pop_front();
                    for (c = 0; c < vmmr_pkg::LANES; c++)
                        if (m_tdata[c*vmmr_pkg::SAMPLE_W +: vmmr_pkg::SAMPLE_W]
                            !== want.lanes[c])
                            report_mismatch($sformatf("result lane %0d", c), want.lanes[c],
                                m_tdata[c*vmmr_pkg::SAMPLE_W +: vmmr_pkg::SAMPLE_W]);
                    if (m_tuser !== want.overflow)
                        report_mismatch("count_overflow",
                                        vmmr_pkg::SAMPLE_W'(want.overflow),
                                        vmmr_pkg::SAMPLE_W'(m_tuser));
                end
            end
        end
    end

    // sample driver
    always @(negedge aclk) begin
        sample_t item;
        if (s_tvalid && !s_taken) begin
            // transaction still waiting for ready
        end else if (s_gap != 0) begin
            s_gap--;
            s_tvalid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            s_gap = $urandom_range(0, 13);
            s_tvalid <= 1'b0;
        end else if (pending_samples.size() != 0) begin
            item = pending_samples.pop_front();
            s_tdata  <= item.data;
            s_tlast  <= item.last;
            s_tvalid <= 1'b1;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // result receiver, with one long hold so the block backs up
    always @(negedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (m_gap != 0) begin
            m_gap--;
            m_tready <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            m_gap = $urandom_range(0, 13);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [vmmr_pkg::CFG_ADDR_W-1:0] addr,
                             input logic [vmmr_pkg::CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (addr)
            vmmr_pkg::CFG_REDUCE_OP: op_shadow = data;
            vmmr_pkg::CFG_IS_VECTOR: vec_shadow = data[0];
            default: ;
        endcase
    endtask

    task automatic push_sample(input logic [vmmr_pkg::SAMPLE_W-1:0] x,
                               input logic [vmmr_pkg::SAMPLE_W-1:0] y,
                               input logic [vmmr_pkg::SAMPLE_W-1:0] z, input logic last);
        sample_t item;
        item.data = {z, y, x};
        item.last = last;
        pending_samples.push_back(item);
    endtask

    // wait until nothing is queued or in flight, then let the divider finish
    task automatic settle();
        while (pending_samples.size() != 0 || s_tvalid || expected_reductions.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [vmmr_pkg::SAMPLE_W-1:0] pick_component();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return 32'hFFFF_FFFF;
            4:       return vmmr_pkg::SAMPLE_W'($urandom_range(0, 512) - 256);
            default: return $urandom();
        endcase
    endfunction

    function automatic int pick_length();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
    endfunction

    initial begin
        int n_queued;
        int len;
        int i;
        int k;
        for (i = 0; i < vmmr_pkg::LANES; i++) lane_acc[i] = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults: mean over three lanes, one-item array at the extremes
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b1);
        // mean with truncation toward zero and sums past 32 bits
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001, 1'b0);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFE, 1'b0);
        push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0002, 1'b1);
        settle();
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MAX);
        push_sample(32'hFFFF_FFFB, 32'h0000_0000, 32'h8000_0000, 1'b0);
        push_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0003, 1'b0);
        push_sample(32'h0000_000A, 32'hFFFF_FFFF, 32'h8000_0000, 1'b1);
        settle();
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MIN);
        push_sample(32'h7FFF_FFFF, 32'h0000_0001, 32'h0000_0000, 1'b0);
        push_sample(32'h8000_0000, 32'h0000_0002, 32'hFFFF_FFF9, 1'b1);
        settle();
        // magnitude of the most negative value saturates
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MAG);
        push_sample(32'h8000_0000, 32'hFFFF_FFFB, 32'h0000_0004, 1'b0);
        push_sample(32'h0000_0003, 32'h0000_0006, 32'hFFFF_FFF9, 1'b1);
        settle();
        write_reg(vmmr_pkg::CFG_REDUCE_OP, OP_ZERO_FIRST);
        push_sample(32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 1'b0);
        push_sample(32'h0000_0004, 32'h0000_0005, 32'h0000_0006, 1'b1);
        settle();
        write_reg(vmmr_pkg::CFG_REDUCE_OP, OP_ZERO_LAST);
        push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1);
        settle();
        // scalar mode zeroes y and z
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MEAN);
        write_reg(vmmr_pkg::CFG_IS_VECTOR, 3'b000);
        push_sample(32'h0000_000A, 32'h0000_0014, 32'h0000_001E, 1'b0);
        push_sample(32'hFFFF_FFFD, 32'h0000_0007, 32'h0000_0007, 1'b1);
        settle();
        // writes past the register list change nothing
        write_reg(CFG_SPARE_2, 3'b111);
        write_reg(CFG_SPARE_3, 3'b101);
        push_sample(32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b1);
        settle();
        // mode switch inside an open array
        write_reg(vmmr_pkg::CFG_IS_VECTOR, 3'b101);
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MAX);
        push_sample(32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 1'b0);
        push_sample(32'h0000_0009, 32'hFFFF_FFF7, 32'h0000_0000, 1'b0);
        settle();
        write_reg(vmmr_pkg::CFG_REDUCE_OP, vmmr_pkg::OP_MIN);
        push_sample(32'h0000_0007, 32'h0000_0007, 32'h0000_0007, 1'b1);
        settle();

        // random batches of arrays between register updates
        n_queued = 0;
        while (n_queued < RANDOM_ITEMS) begin
            idle_en = (n_queued < RANDOM_ITEMS - 200) && ($urandom_range(0, 3) != 0);
            if (n_queued > 400) hold_armed = 1'b1;
            settle();
            if ($urandom_range(0, 4) == 0) begin
                // leave an array open across the register update
                len = $urandom_range(1, 4);
                for (i = 0; i < len; i++)
                    push_sample(pick_component(), pick_component(), pick_component(), 1'b0);
                n_queued += len;
                settle();
            end
            if ($urandom_range(0, 3) == 0)
                write_reg(vmmr_pkg::CFG_REDUCE_OP,
                          3'($urandom_range(OP_ZERO_FIRST, OP_ZERO_LAST)));
            else
                write_reg(vmmr_pkg::CFG_REDUCE_OP,
                          3'($urandom_range(vmmr_pkg::OP_MEAN, vmmr_pkg::OP_MAG)));
            if ($urandom_range(0, 1) == 0)
                write_reg(vmmr_pkg::CFG_IS_VECTOR, 3'($urandom_range(0, 7)));
            if ($urandom_range(0, 9) == 0)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, 3'($urandom()));
            for (k = $urandom_range(2, 10); k > 0; k--) begin
                len = pick_length();
                for (i = 0; i < len; i++)
                    push_sample(pick_component(), pick_component(), pick_component(),
                                i == len - 1);
                n_queued += len;
            end
        end
        settle();

        if (mismatches == 0 && expected_reductions.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/vmmr_pkg.sv
rtl/vmmr_div.sv
rtl/vmmr_datapath.sv
rtl/vmmr_ctrl.sv
rtl/vector_min_max_mean_reducer_top.sv
verif/vector_min_max_mean_reducer_top_tb.sv
